/* design/sks_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sks_pkg
// Shared constants, types and the microcode table of the sorted key search.
// ----------------------------------------------------------------------------
package sks_pkg;

  localparam int TABLE_DEPTH = 1024;
  localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

  localparam int KEY_W    = 64;
  localparam int CMD_W    = 2;
  localparam int FLAGS_W  = 3;
  localparam int STATUS_W = 2;
  localparam int INDEX_W  = 10;

  localparam int S_TDATA_W = 64;
  localparam int S_TUSER_W = 5;
  localparam int M_TDATA_W = 80;
  localparam int M_TUSER_W = 2;

  localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_APPEND = 2'd1;
  localparam logic [CMD_W-1:0] CMD_SEARCH = 2'd2;

  localparam int FLAG_EQ_BIT = 0;
  localparam int FLAG_GT_BIT = 1;
  localparam int FLAG_LT_BIT = 2;

  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;

  typedef enum logic [4:0] {
    U_IDLE, U_DISP, U_DISP2, U_DISP3, U_CLR, U_NOP, U_APP, U_APP_FULL, U_APP_WR,
    U_PROBE, U_CMP, U_HIT, U_HIT_EQ, U_HIT2, U_HIT_GT, U_HIT_LT, U_MISS,
    U_MISS_GT, U_MISS2, U_PICK_LT, U_RD_LO, U_RD_LOM1, U_FETCH, U_NOTF, U_DONE
  } step_t;

  typedef enum logic [3:0] {
    C_ALWAYS, C_NO_IN, C_CMD_CLR, C_CMD_APP, C_CMD_SRCH, C_FULL, C_LO_GE_HI,
    C_KEY_EQ, C_FLAG_EQ, C_FLAG_GT, C_FLAG_LT, C_LO_LT_N, C_LO_ZERO, C_OUT_BUSY
  } cond_t;

  typedef enum logic [1:0] {A_MID, A_LO, A_LOM1, A_CNT} addr_sel_t;
  typedef enum logic [1:0] {CN_HOLD, CN_CLR, CN_INC} cnt_op_t;
  typedef enum logic [1:0] {LO_HOLD, LO_CMP, LO_MID1, LO_MID} lo_op_t;
  typedef enum logic [2:0] {R_NONE, R_ZERO, R_NOTF, R_FULL, R_APPEND, R_RAM} res_op_t;

  typedef struct packed {
    addr_sel_t addr_sel;
    logic      rd_en;
    logic      wr_en;
    cnt_op_t   cnt_op;
    lo_op_t    lo_op;
    res_op_t   res_op;
    logic      out_load;
  } ctl_t;

  typedef struct packed {
    step_t t_true;
    step_t t_false;
    cond_t cond;
    ctl_t  ctl;
  } uword_t;

  // datapath status seen by the branch logic
  typedef struct packed {
    logic in_valid;
    logic cmd_clr;
    logic cmd_app;
    logic cmd_srch;
    logic full;
    logic lo_ge_hi;
    logic key_eq;
    logic flag_eq;
    logic flag_gt;
    logic flag_lt;
    logic lo_lt_n;
    logic lo_zero;
    logic out_busy;
  } stat_t;

  localparam ctl_t CTL_NOP = '{addr_sel: A_MID, rd_en: 1'b0, wr_en: 1'b0,
                               cnt_op: CN_HOLD, lo_op: LO_HOLD, res_op: R_NONE,
                               out_load: 1'b0};

  function automatic uword_t ucode(step_t s);
    uword_t w;
    w.ctl     = CTL_NOP;
    w.cond    = C_ALWAYS;
    w.t_true  = U_IDLE;
    w.t_false = U_IDLE;
    case (s)
      U_IDLE: begin
        w.cond = C_NO_IN; w.t_true = U_IDLE; w.t_false = U_DISP;
      end
      U_DISP: begin
        w.cond = C_CMD_CLR; w.t_true = U_CLR; w.t_false = U_DISP2;
      end
      U_DISP2: begin
        w.cond = C_CMD_APP; w.t_true = U_APP; w.t_false = U_DISP3;
      end
      U_DISP3: begin
        w.cond = C_CMD_SRCH; w.t_true = U_PROBE; w.t_false = U_NOP;
      end
      U_CLR: begin
        w.ctl.cnt_op = CN_CLR; w.ctl.res_op = R_ZERO; w.t_true = U_DONE;
      end
      U_NOP: begin
        w.ctl.res_op = R_ZERO; w.t_true = U_DONE;
      end
      U_APP: begin
        w.cond = C_FULL; w.t_true = U_APP_FULL; w.t_false = U_APP_WR;
      end
      U_APP_FULL: begin
        w.ctl.res_op = R_FULL; w.t_true = U_DONE;
      end
      U_APP_WR: begin
        w.ctl.addr_sel = A_CNT; w.ctl.wr_en = 1'b1; w.ctl.cnt_op = CN_INC;
        w.ctl.res_op = R_APPEND; w.t_true = U_DONE;
      end
      U_PROBE: begin
        w.ctl.addr_sel = A_MID; w.ctl.rd_en = 1'b1;
        w.cond = C_LO_GE_HI; w.t_true = U_MISS; w.t_false = U_CMP;
      end
      U_CMP: begin
        w.ctl.lo_op = LO_CMP;
        w.cond = C_KEY_EQ; w.t_true = U_HIT; w.t_false = U_PROBE;
      end
      U_HIT: begin
        w.cond = C_FLAG_EQ; w.t_true = U_HIT_EQ; w.t_false = U_HIT2;
      end
      U_HIT_EQ: begin
        w.ctl.addr_sel = A_MID; w.ctl.rd_en = 1'b1; w.t_true = U_FETCH;
      end
      U_HIT2: begin
        w.cond = C_FLAG_GT; w.t_true = U_HIT_GT; w.t_false = U_HIT_LT;
      end
      U_HIT_GT: begin
        w.ctl.lo_op = LO_MID1; w.t_true = U_MISS;
      end
      U_HIT_LT: begin
        w.ctl.lo_op = LO_MID; w.t_true = U_PICK_LT;
      end
      U_MISS: begin
        w.cond = C_FLAG_GT; w.t_true = U_MISS_GT; w.t_false = U_MISS2;
      end
      U_MISS_GT: begin
        w.cond = C_LO_LT_N; w.t_true = U_RD_LO; w.t_false = U_NOTF;
      end
      U_MISS2: begin
        w.cond = C_FLAG_LT; w.t_true = U_PICK_LT; w.t_false = U_NOTF;
      end
      U_PICK_LT: begin
        w.cond = C_LO_ZERO; w.t_true = U_NOTF; w.t_false = U_RD_LOM1;
      end
      U_RD_LO: begin
        w.ctl.addr_sel = A_LO; w.ctl.rd_en = 1'b1; w.t_true = U_FETCH;
      end
      U_RD_LOM1: begin
        w.ctl.addr_sel = A_LOM1; w.ctl.rd_en = 1'b1; w.t_true = U_FETCH;
      end
      U_FETCH: begin
        w.ctl.res_op = R_RAM; w.t_true = U_DONE;
      end
      U_NOTF: begin
        w.ctl.res_op = R_NOTF; w.t_true = U_DONE;
      end
      U_DONE: begin
        w.ctl.out_load = 1'b1;
        w.cond = C_OUT_BUSY; w.t_true = U_DONE; w.t_false = U_IDLE;
      end
      default: begin
        w.t_true = U_IDLE; w.t_false = U_IDLE;
      end
    endcase
    return w;
  endfunction

endpackage
`default_nettype wire

/* design/sorted_key_neighbor_search_top.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sorted_key_neighbor_search_top
// Sorted 64-bit key table with clear, append and neighbor search.
// ----------------------------------------------------------------------------
// One command word is taken at a time and gives one result word. A microcoded
// sequencer steps a small datapath around a single-port key table with
// registered read. A search passes through the dispatch steps, then binary
// search probes, each a table read and a compare, then settles the neighbor,
// fetches it, loads the output register and returns to idle. With 1024 keys
// a search makes at most 11 compare probes. The result waits in an output
// register, so a new command is taken while the previous result is still
// unread; the sequencer only stalls while that register is still full.
module sorted_key_neighbor_search_top (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            s_axis_tvalid,
  output logic                                 s_axis_tready,
  input  wire logic [sks_pkg::S_TDATA_W-1:0]   s_axis_tdata,  // search_key
  input  wire logic [sks_pkg::S_TUSER_W-1:0]   s_axis_tuser,  // command, op_flags
  output logic                                 m_axis_tvalid,
  input  wire logic                            m_axis_tready,
  output logic      [sks_pkg::M_TDATA_W-1:0]   m_axis_tdata,  // entry_index, entry_key
  output logic      [sks_pkg::M_TUSER_W-1:0]   m_axis_tuser   // status
);

  sks_pkg::step_t step;
  sks_pkg::ctl_t  ctl;
  sks_pkg::stat_t stat;
  logic           in_accept;
  logic [sks_pkg::STATUS_W-1:0] out_status;
  logic [sks_pkg::INDEX_W-1:0]  out_index;
  logic [sks_pkg::KEY_W-1:0]    out_key;

  assign s_axis_tready = (step == sks_pkg::U_IDLE) && !rst;
  assign in_accept     = s_axis_tvalid && s_axis_tready;

  sks_seq u_seq (
    .clk  (clk),
    .rst  (rst),
    .stat (stat),
    .step (step),
    .ctl  (ctl)
  );

  sks_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .ctl        (ctl),
    .in_valid   (s_axis_tvalid),
    .in_accept  (in_accept),
    .in_cmd     (s_axis_tuser[sks_pkg::CMD_W-1:0]),
    .in_key     (s_axis_tdata[sks_pkg::KEY_W-1:0]),
    .in_flags   (s_axis_tuser[sks_pkg::CMD_W +: sks_pkg::FLAGS_W]),
    .out_ready  (m_axis_tready),
    .stat       (stat),
    .out_valid  (m_axis_tvalid),
    .out_status (out_status),
    .out_index  (out_index),
    .out_key    (out_key)
  );

  assign m_axis_tdata = sks_pkg::M_TDATA_W'({out_key, out_index});
  assign m_axis_tuser = out_status;

endmodule
`default_nettype wire

/* design/sks_ram.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sks_ram
// Generic single-port RAM, registered read.
// ----------------------------------------------------------------------------
module sks_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024
) (
  input  wire logic                                   clk,
  input  wire logic                                   we,
  input  wire logic                                   re,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
  input  wire logic [WIDTH-1:0]                       wdata,
  output logic      [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule
`default_nettype wire

/* design/sks_seq.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sks_seq
// Microcode sequencer: step register, control ROM and two-way branch.
// ----------------------------------------------------------------------------
module sks_seq (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire sks_pkg::stat_t stat,
  output sks_pkg::step_t     step,
  output sks_pkg::ctl_t      ctl
);

  sks_pkg::step_t  step_next;
  sks_pkg::uword_t uw;
  logic            taken;

  always_comb begin
    uw = sks_pkg::ucode(step);
  end

  always_comb begin
    case (uw.cond)
      sks_pkg::C_ALWAYS:   taken = 1'b1;
      sks_pkg::C_NO_IN:    taken = !stat.in_valid;
      sks_pkg::C_CMD_CLR:  taken = stat.cmd_clr;
      sks_pkg::C_CMD_APP:  taken = stat.cmd_app;
      sks_pkg::C_CMD_SRCH: taken = stat.cmd_srch;
      sks_pkg::C_FULL:     taken = stat.full;
      sks_pkg::C_LO_GE_HI: taken = stat.lo_ge_hi;
      sks_pkg::C_KEY_EQ:   taken = stat.key_eq;
      sks_pkg::C_FLAG_EQ:  taken = stat.flag_eq;
      sks_pkg::C_FLAG_GT:  taken = stat.flag_gt;
      sks_pkg::C_FLAG_LT:  taken = stat.flag_lt;
      sks_pkg::C_LO_LT_N:  taken = stat.lo_lt_n;
      sks_pkg::C_LO_ZERO:  taken = stat.lo_zero;
      sks_pkg::C_OUT_BUSY: taken = stat.out_busy;
      default:             taken = 1'b1;
    endcase
    step_next = taken ? uw.t_true : uw.t_false;
  end

  always_comb begin
    ctl = uw.ctl;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= sks_pkg::U_IDLE;
    end else begin
      step <= step_next;
    end
  end

endmodule
`default_nettype wire

/* design/sks_dp.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sks_dp
// Search datapath: key table, count, search bounds, result and output words.
// ----------------------------------------------------------------------------
module sks_dp (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire sks_pkg::ctl_t                  ctl,
  input  wire logic                           in_valid,
  input  wire logic                           in_accept,
  input  wire logic [sks_pkg::CMD_W-1:0]      in_cmd,
  input  wire logic [sks_pkg::KEY_W-1:0]      in_key,
  input  wire logic [sks_pkg::FLAGS_W-1:0]    in_flags,
  input  wire logic                           out_ready,
  output sks_pkg::stat_t                      stat,
  output logic                                out_valid,
  output logic      [sks_pkg::STATUS_W-1:0]   out_status,
  output logic      [sks_pkg::INDEX_W-1:0]    out_index,
  output logic      [sks_pkg::KEY_W-1:0]      out_key
);

  localparam int IDX_W = sks_pkg::IDX_W;
  localparam int CNT_W = sks_pkg::CNT_W;

  logic [sks_pkg::CMD_W-1:0]    cmd;
  logic [sks_pkg::KEY_W-1:0]    key;
  logic [sks_pkg::FLAGS_W-1:0]  flags;
  logic [CNT_W-1:0]             count;
  logic [CNT_W-1:0]             lo;
  logic [CNT_W-1:0]             hi1;   // one past the upper bound
  logic [CNT_W:0]               mid_sum;
  logic [IDX_W-1:0]             mid;
  logic [CNT_W-1:0]             mid_inc;
  logic [IDX_W-1:0]             addr;
  logic [IDX_W-1:0]             rd_idx;
  logic [sks_pkg::KEY_W-1:0]    rdata;
  logic [sks_pkg::STATUS_W-1:0] res_status;
  logic [sks_pkg::INDEX_W-1:0]  res_idx;
  logic [sks_pkg::KEY_W-1:0]    res_key;
  logic                         out_busy;

  // floor((lo + hi) / 2) with hi = hi1 - 1
  assign mid_sum = {1'b0, lo} + {1'b0, hi1} - (CNT_W + 1)'(1);
  assign mid     = mid_sum[IDX_W:1];
  assign mid_inc = CNT_W'(mid) + CNT_W'(1);

  always_comb begin
    case (ctl.addr_sel)
      sks_pkg::A_MID:  addr = mid;
      sks_pkg::A_LO:   addr = lo[IDX_W-1:0];
      sks_pkg::A_LOM1: addr = IDX_W'(lo - CNT_W'(1));
      sks_pkg::A_CNT:  addr = count[IDX_W-1:0];
      default:         addr = mid;
    endcase
  end

  sks_ram #(
    .WIDTH (sks_pkg::KEY_W),
    .DEPTH (sks_pkg::TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (ctl.wr_en),
    .re    (ctl.rd_en),
    .addr  (addr),
    .wdata (key),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (in_accept) begin
      cmd   <= in_cmd;
      key   <= in_key;
      flags <= in_flags;
    end
    if (ctl.rd_en) begin
      rd_idx <= addr;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      case (ctl.cnt_op)
        sks_pkg::CN_CLR: count <= '0;
        sks_pkg::CN_INC: count <= count + CNT_W'(1);
        default:         count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      lo  <= '0;
      hi1 <= count;
    end else begin
      case (ctl.lo_op)
        sks_pkg::LO_CMP: begin
          if (rdata < key) begin
            lo <= mid_inc;
          end else if (rdata > key) begin
            hi1 <= CNT_W'(mid);
          end
        end
        sks_pkg::LO_MID1: lo <= mid_inc;
        sks_pkg::LO_MID:  lo <= CNT_W'(mid);
        default: begin
          lo <= lo;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (ctl.res_op)
      sks_pkg::R_ZERO: begin
        res_status <= sks_pkg::ST_OK; res_idx <= '0; res_key <= '0;
      end
      sks_pkg::R_NOTF: begin
        res_status <= sks_pkg::ST_NOT_FOUND; res_idx <= '0; res_key <= '0;
      end
      sks_pkg::R_FULL: begin
        res_status <= sks_pkg::ST_FULL; res_idx <= '0; res_key <= '0;
      end
      sks_pkg::R_APPEND: begin
        res_status <= sks_pkg::ST_OK;
        res_idx    <= sks_pkg::INDEX_W'(count[IDX_W-1:0]);
        res_key    <= key;
      end
      sks_pkg::R_RAM: begin
        res_status <= sks_pkg::ST_OK;
        res_idx    <= sks_pkg::INDEX_W'(rd_idx);
        res_key    <= rdata;
      end
      default: begin
        res_status <= res_status;
      end
    endcase
  end

  // output word register, frees the search side from the consumer
  assign out_busy = out_valid && !out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctl.out_load && !out_busy) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.out_load && !out_busy) begin
      out_status <= res_status;
      out_index  <= res_idx;
      out_key    <= res_key;
    end
  end

  always_comb begin
    stat.in_valid = in_valid;
    stat.cmd_clr  = (cmd == sks_pkg::CMD_CLEAR);
    stat.cmd_app  = (cmd == sks_pkg::CMD_APPEND);
    stat.cmd_srch = (cmd == sks_pkg::CMD_SEARCH);
    stat.full     = (count >= CNT_W'(sks_pkg::TABLE_DEPTH));
    stat.lo_ge_hi = (lo >= hi1);
    stat.key_eq   = (rdata == key);
    stat.flag_eq  = flags[sks_pkg::FLAG_EQ_BIT];
    stat.flag_gt  = flags[sks_pkg::FLAG_GT_BIT];
    stat.flag_lt  = flags[sks_pkg::FLAG_LT_BIT];
    stat.lo_lt_n  = (lo < count);
    stat.lo_zero  = (lo == '0);
    stat.out_busy = out_busy;
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(sks_pkg::TABLE_DEPTH))
    else $error("key count beyond table depth");

  a_wr_not_full: assert property (@(posedge clk) disable iff (rst)
    ctl.wr_en |-> !stat.full)
    else $error("table write while full");

  a_wr_count: assert property (@(posedge clk) disable iff (rst)
    ctl.wr_en |=> count == $past(count) + CNT_W'(1))
    else $error("append did not advance count");

  a_mid_range: assert property (@(posedge clk) disable iff (rst)
    (ctl.rd_en && ctl.addr_sel == sks_pkg::A_MID && lo < hi1)
      |-> (CNT_W'(mid) >= lo && CNT_W'(mid) < hi1))
    else $error("probe outside search range");

endmodule
`default_nettype wire

/* sim/sorted_key_neighbor_search_top_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_key_neighbor_search_top_tb
// Self-checking bench for the sorted key table: clear, append and neighbor
// search words go in on the slave stream; every result word is checked field
// by field against a local copy of the table and the same binary search.
// Directed corner cases come first, then a full table, random traffic under
// several idle/stall mixes, and a long output hold-off that backs up the input.
// ----------------------------------------------------------------------------
module sorted_key_neighbor_search_top_tb;

  localparam int CMD_W       = sks_pkg::CMD_W;
  localparam int FLAGS_W     = sks_pkg::FLAGS_W;
  localparam int KEY_W       = sks_pkg::KEY_W;
  localparam int STATUS_W    = sks_pkg::STATUS_W;
  localparam int INDEX_W     = sks_pkg::INDEX_W;
  localparam int S_TDATA_W   = sks_pkg::S_TDATA_W;
  localparam int S_TUSER_W   = sks_pkg::S_TUSER_W;
  localparam int M_TDATA_W   = sks_pkg::M_TDATA_W;
  localparam int M_TUSER_W   = sks_pkg::M_TUSER_W;
  localparam int TABLE_DEPTH = sks_pkg::TABLE_DEPTH;
  localparam int FLAG_EQ_BIT = sks_pkg::FLAG_EQ_BIT;
  localparam int FLAG_GT_BIT = sks_pkg::FLAG_GT_BIT;
  localparam int FLAG_LT_BIT = sks_pkg::FLAG_LT_BIT;

  localparam logic [CMD_W-1:0]    CMD_CLEAR    = sks_pkg::CMD_CLEAR;
  localparam logic [CMD_W-1:0]    CMD_APPEND   = sks_pkg::CMD_APPEND;
  localparam logic [CMD_W-1:0]    CMD_SEARCH   = sks_pkg::CMD_SEARCH;
  localparam logic [STATUS_W-1:0] ST_OK        = sks_pkg::ST_OK;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = sks_pkg::ST_NOT_FOUND;
  localparam logic [STATUS_W-1:0] ST_FULL      = sks_pkg::ST_FULL;

  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int DRAIN_CYCLES = 60;
  localparam int HOLD_CYCLES  = 400;

  localparam logic [CMD_W-1:0]   CMD_UNUSED   = 2'd3;
  localparam logic [FLAGS_W-1:0] F_NONE       = '0;
  localparam logic [FLAGS_W-1:0] F_EQ         = 3'b1 << FLAG_EQ_BIT;
  localparam logic [FLAGS_W-1:0] F_GT         = 3'b1 << FLAG_GT_BIT;
  localparam logic [FLAGS_W-1:0] F_LT         = 3'b1 << FLAG_LT_BIT;
  localparam logic [KEY_W-1:0]   KEY_ALL_ONES = '1;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [INDEX_W-1:0]  index;
    logic [KEY_W-1:0]    key;
  } response_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [S_TDATA_W-1:0] s_axis_tdata = '0;   // search_key
  logic [S_TUSER_W-1:0] s_axis_tuser = '0;   // command [1:0], op_flags [4:2]
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [M_TDATA_W-1:0] m_axis_tdata;        // entry_index [9:0], entry_key [73:10]
  logic [M_TUSER_W-1:0] m_axis_tuser;        // status

  sorted_key_neighbor_search_top dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #5 clk = ~clk;

  // local copy of the table
  logic [KEY_W-1:0] key_mem [TABLE_DEPTH];
  int               key_total = 0;

  response_t expected_responses [$];
  response_t head;

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  bit hold_rx        = 1'b0;
  int cycle_count    = 0;
  int fail_count     = 0;
  int sent_words     = 0;
  int checked_words  = 0;
  int search_words   = 0;
  int full_reports   = 0;
  int max_table      = 0;

  function automatic response_t entry_at(int idx);
    response_t r;
    r.status = ST_OK;
    r.index  = idx[INDEX_W-1:0];
    r.key    = key_mem[idx];
    return r;
  endfunction

  // Expected result word of one command; updates the local table.
  function automatic response_t table_response(logic [CMD_W-1:0] cmd,
                                               logic [KEY_W-1:0] key,
                                               logic [FLAGS_W-1:0] flags);
    response_t r;
    int lo, hi, mid;
    bit scanning, settled;
    r = '{status: ST_OK, index: '0, key: '0};
    case (cmd)
      CMD_CLEAR: begin
        key_total = 0;
      end
      CMD_APPEND: begin
        if (key_total >= TABLE_DEPTH) begin
          r.status = ST_FULL;
        end else begin
          key_mem[key_total] = key;
          r = entry_at(key_total);
          key_total++;
        end
      end
      CMD_SEARCH: begin
        r.status = ST_NOT_FOUND;
        lo = 0;
        hi = key_total - 1;
        settled = (key_total == 0);
        scanning = !settled;
        while (scanning && lo <= hi) begin
          mid = (lo + hi) / 2;
          if (key_mem[mid] < key) begin
            lo = mid + 1;
          end else if (key_mem[mid] > key) begin
            hi = mid - 1;
          end else begin
            scanning = 1'b0;
            if (flags[FLAG_EQ_BIT]) begin
              r = entry_at(mid);
              settled = 1'b1;
            end else if (flags[FLAG_GT_BIT]) begin
              lo = mid + 1;   // falls through to the successor rule
            end else begin
              if (mid > 0) r = entry_at(mid - 1);
              settled = 1'b1;
            end
          end
        end
        if (!settled) begin
          if (flags[FLAG_GT_BIT]) begin
            if (lo < key_total) r = entry_at(lo);
          end else if (flags[FLAG_LT_BIT]) begin
            if (lo > 0) r = entry_at(lo - 1);
          end
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic send_word(input logic [CMD_W-1:0] cmd, input logic [KEY_W-1:0] key,
                           input logic [FLAGS_W-1:0] flags);
    response_t r;
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= key;
    s_axis_tuser  <= {flags, cmd};
    do @(posedge clk); while (!s_axis_tready);
    r = table_response(cmd, key, flags);
    expected_responses.push_back(r);
    sent_words++;
    if (cmd == CMD_SEARCH) search_words++;
    if (r.status == ST_FULL) full_reports++;
    if (key_total > max_table) max_table = key_total;
  endtask

  function automatic logic [KEY_W-1:0] random_key();
    return {$urandom, $urandom};
  endfunction

  // Mostly keys near table contents so hits, neighbors and edges all occur.
  function automatic logic [KEY_W-1:0] pick_search_key();
    logic [KEY_W-1:0] k;
    int sel;
    sel = $urandom_range(99);
    if (key_total > 0 && sel < 65) begin
      k = key_mem[$urandom_range(key_total - 1)];
      case ($urandom_range(2))
        1: k = k + 1;
        2: k = k - 1;
        default: ;
      endcase
    end else if (sel < 78) begin
      k = $urandom_range(1) ? KEY_ALL_ONES : '0;
    end else begin
      k = random_key();
    end
    return k;
  endfunction

  // Appends n ascending keys (disorder_pct% random), whole range or packed densely.
  task automatic append_sorted_keys(input int n, input bit dense, input int disorder_pct);
    logic [KEY_W-1:0] span, base, k;
    int stride;
    span   = KEY_ALL_ONES / (n + 1);
    base   = random_key() >> 1;
    stride = $urandom_range(2, 5);
    for (int i = 0; i < n; i++) begin
      if (dense) k = base + 64'(i) * 64'(stride);
      else       k = span * 64'(i) + (random_key() % span);
      if ($urandom_range(99) < disorder_pct) k = random_key();
      send_word(CMD_APPEND, k, 3'($urandom_range(7)));
    end
  endtask

  task automatic test_directed_cases();
    logic [KEY_W-1:0] name_key;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    name_key = 64'h4142_4300_0000_0000;   // "ABC" zero padded
    send_word(CMD_CLEAR, KEY_ALL_ONES, F_EQ | F_GT | F_LT);
    send_word(CMD_SEARCH, '0, F_EQ | F_GT | F_LT);          // empty table
    send_word(CMD_APPEND, '0, F_NONE);
    send_word(CMD_APPEND, 64'h100, F_NONE);
    send_word(CMD_APPEND, 64'h200, F_NONE);
    send_word(CMD_APPEND, name_key, F_NONE);
    send_word(CMD_APPEND, KEY_ALL_ONES, F_NONE);
    send_word(CMD_SEARCH, '0, F_NONE);                      // hit first, no predecessor
    send_word(CMD_SEARCH, '0, F_LT);
    send_word(CMD_SEARCH, 64'h200, F_EQ);
    send_word(CMD_SEARCH, 64'h200, F_GT);
    send_word(CMD_SEARCH, 64'h200, F_LT);
    send_word(CMD_SEARCH, 64'h200, F_GT | F_LT);
    send_word(CMD_SEARCH, 64'h200, F_NONE);
    send_word(CMD_SEARCH, KEY_ALL_ONES, F_GT);              // hit last, no successor
    send_word(CMD_SEARCH, KEY_ALL_ONES, F_EQ | F_GT | F_LT);
    send_word(CMD_SEARCH, 64'h150, F_GT);
    send_word(CMD_SEARCH, 64'h150, F_LT);
    send_word(CMD_SEARCH, 64'h150, F_GT | F_LT);
    send_word(CMD_SEARCH, 64'h150, F_EQ);
    send_word(CMD_SEARCH, KEY_ALL_ONES - 1, F_GT);
    send_word(CMD_UNUSED, KEY_ALL_ONES, F_EQ | F_GT | F_LT);
    send_word(CMD_APPEND, 64'h50, F_NONE);                  // out of order
    send_word(CMD_SEARCH, 64'h50, F_EQ | F_LT);
    send_word(CMD_SEARCH, name_key + 1, F_LT);
  endtask

  task automatic test_full_table();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    send_word(CMD_CLEAR, '0, F_NONE);
    append_sorted_keys(TABLE_DEPTH, 1'b0, 0);
    send_word(CMD_APPEND, KEY_ALL_ONES, F_NONE);
    send_word(CMD_APPEND, random_key(), F_EQ);
    repeat (30) send_word(CMD_SEARCH, pick_search_key(), 3'($urandom_range(7)));
    send_word(CMD_SEARCH, key_mem[TABLE_DEPTH-1], F_EQ);
    send_word(CMD_SEARCH, '0, F_LT);
    send_word(CMD_SEARCH, KEY_ALL_ONES, F_GT);
    send_word(CMD_CLEAR, '0, F_NONE);
  endtask

  task automatic test_random_traffic(input int idle_pct, input int stall_pct,
                                     input int quota);
    int start, n, burst, sel;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    start = sent_words;
    while (sent_words - start < quota) begin
      if (key_total >= 600 || $urandom_range(99) < 80)
        send_word(CMD_CLEAR, random_key(), 3'($urandom_range(7)));
      n = ($urandom_range(9) == 0) ? $urandom_range(100, 300) : $urandom_range(0, 40);
      append_sorted_keys(n, 1'($urandom_range(1)), 4);
      burst = $urandom_range(5, 30);
      repeat (burst) begin
        sel = $urandom_range(99);
        if (sel < 3)      send_word(CMD_UNUSED, random_key(), 3'($urandom_range(7)));
        else if (sel < 5) send_word(CMD_CLEAR, random_key(), 3'($urandom_range(7)));
        else if (sel < 8) send_word(CMD_APPEND, random_key(), 3'($urandom_range(7)));
        else send_word(CMD_SEARCH, pick_search_key(), 3'($urandom_range(7)));
      end
    end
  endtask

  // Output held off while commands keep coming, so the input must stall.
  task automatic test_output_holdoff();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    send_word(CMD_CLEAR, '0, F_NONE);
    append_sorted_keys(20, 1'b0, 0);
    fork
      begin
        hold_rx = 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_rx = 1'b0;
      end
      repeat (40) send_word(CMD_SEARCH, pick_search_key(), 3'($urandom_range(7)));
    join
  endtask

  always @(negedge clk) begin
    if (hold_rx) m_axis_tready <= 1'b0;
    else         m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (expected_responses.size() == 0) begin
        $error("result word with no command pending: status %0d index %0d key %h",
               m_axis_tuser, m_axis_tdata[INDEX_W-1:0], m_axis_tdata[INDEX_W +: KEY_W]);
        fail_count++;
      end else begin
        head = expected_responses.pop_front();
        checked_words++;
        if (m_axis_tuser !== head.status) begin
          $error("status: expected %0d, got %0d", head.status, m_axis_tuser);
          fail_count++;
        end
        if (m_axis_tdata[INDEX_W-1:0] !== head.index) begin
          $error("entry_index: expected %0d, got %0d", head.index,
                 m_axis_tdata[INDEX_W-1:0]);
          fail_count++;
        end
        if (m_axis_tdata[INDEX_W +: KEY_W] !== head.key) begin
          $error("entry_key: expected %h, got %h", head.key,
                 m_axis_tdata[INDEX_W +: KEY_W]);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               expected_responses.size());
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_directed_cases();
    test_full_table();
    test_random_traffic(0, 0, 200);
    test_random_traffic(86, 0, 200);
    test_random_traffic(0, 86, 200);
    test_random_traffic(38, 38, 200);
    test_output_holdoff();
    @(negedge clk);
    s_axis_tvalid  <= 1'b0;
    recv_stall_pct = 0;
    while (expected_responses.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("%0d command words, %0d result words checked, %0d searches, %0d full reports",
             sent_words, checked_words, search_words, full_reports);
    $display("largest table %0d keys; idle/stall mixes plus a %0d-cycle output hold-off",
             max_table, HOLD_CYCLES);
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
